[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled during reset.
`define RBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds while reset is applied.
`define RBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rbs_pkg.sv]
// ----------------------------------------------------------------------------
// rbs_pkg
// Types and constants shared by the retry backoff scheduler files.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int TIME_W   = 32;
    localparam int FRAC_W   = 8;
    localparam int GF_W     = 13;
    localparam int PCT_W    = 7;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 3;
    localparam int PROD_W   = TIME_W + GF_W;
    localparam int DVD_W    = TIME_W;
    localparam int DEN_W    = TIME_W + 1;
    localparam int DCNT_W   = 6;

    // Reciprocal of 100 for a 32-bit dividend: exact quotient after the shift.
    localparam int                RCP_SH  = 37;
    localparam logic [TIME_W-1:0] RCP_100 = 32'h51EB_851F;

    // Reciprocal of 100 for the small remainder product (below 5000).
    localparam int                FRC_W   = 13;
    localparam int                FRC_SH  = 19;
    localparam logic [FRC_W-1:0]  RCP_FRC = 13'd5243;

    // Opcodes of an input transaction.
    localparam logic [OP_W-1:0] OP_FAIL  = 2'd0;
    localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_MIN     = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX     = 3'd1;
    localparam logic [IDX_W-1:0] REG_GROWTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_JITTER  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PLATEAU = 3'd4;

    // Reset values of the registers.
    localparam logic [TIME_W-1:0] RST_MIN     = 32'd1000;
    localparam logic [TIME_W-1:0] RST_MAX     = 32'd300000;
    localparam logic [GF_W-1:0]   RST_GROWTH  = 13'd512;
    localparam logic [PCT_W-1:0]  RST_JITTER  = 7'd10;
    localparam logic [TIME_W-1:0] RST_PLATEAU = 32'd60000;

    localparam logic [PCT_W-1:0]  PCT_CAP     = 7'd50;
    localparam logic [TIME_W-1:0] TIME_HALF   = 32'h8000_0000;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_GMUL = 9'b0_0000_0010,
        S_GCHK = 9'b0_0000_0100,
        S_FIX  = 9'b0_0000_1000,
        S_PMUL = 9'b0_0001_0000,
        S_DQ   = 9'b0_0010_0000,
        S_DADJ = 9'b0_0100_0000,
        S_DM   = 9'b0_1000_0000,
        S_FIN  = 9'b1_0000_0000
    } t_state;

endpackage

[hw/rtl/rbs_if.sv]
// ----------------------------------------------------------------------------
// rbs_if
// Valid/ready channels of the retry backoff scheduler.
// ----------------------------------------------------------------------------
interface rbs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [31:0] floor_ms;
    logic [31:0] random_value;
    modport source (output valid, opcode, now_ms, floor_ms, random_value, input ready);
    modport sink   (input valid, opcode, now_ms, floor_ms, random_value, output ready);
endinterface

interface rbs_out_if;
    logic        valid;
    logic        ready;
    logic        attempt_allowed;
    logic [31:0] delay_ms;
    logic [31:0] next_attempt_ms;
    logic [31:0] attempt_total;
    modport source (output valid, attempt_allowed, delay_ms, next_attempt_ms,
                    attempt_total, input ready);
    modport sink   (input valid, attempt_allowed, delay_ms, next_attempt_ms,
                    attempt_total, output ready);
endinterface

interface rbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/rbs_div.sv]
// ----------------------------------------------------------------------------
// rbs_div
// Restoring divider, one quotient bit per cycle, giving the remainder.
// ----------------------------------------------------------------------------
module rbs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rbs_pkg::DVD_W-1:0]   i_dividend,
    input  logic [rbs_pkg::DEN_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [rbs_pkg::DEN_W-1:0]   o_rem
);
    import rbs_pkg::*;
    `include "assert_macros.svh"

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DCNT_W-1:0]   r_cnt, n_cnt;
    logic [DVD_W-1:0]    r_quo, n_quo;
    logic [DEN_W-1:0]    r_rem, n_rem;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [DEN_W:0]      trial;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_quo[DVD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(trial - {1'b0, r_den});
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `RBS_ASSERT(a_div_cnt, i_clk, i_rst_n, r_busy |-> (r_cnt < DCNT_W'(DVD_W)), "divider step count overran")
    `RBS_ASSERT(a_div_done, i_clk, i_rst_n, r_done |-> !r_busy, "divider done while still busy")

endmodule

[hw/rtl/retry_backoff_scheduler.sv]
// ----------------------------------------------------------------------------
// retry_backoff_scheduler
// Exponential backoff with plateau, clamping and jitter under a sequencer.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Any opcode but a failure goes from
// acceptance straight to the result state. A failure runs growth steps, at
// most as many as the failure count and fewer once the value stops changing.
// Each growth step uses the shared 32x13 multiplier and then a clamp/compare
// step; the jitter span (value*pct/100) is formed in the PMUL, DQ and DADJ
// states by reciprocal multiplication, and unless the span is zero the random
// draw modulo 2*span+1 passes through the 32-step divider. A result that is
// not taken holds the sequencer in its last state. The output register lets
// a new transaction enter while a result still waits to be taken.
module retry_backoff_scheduler (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rbs_in_if.sink    i_in,
    rbs_out_if.source o_out,
    rbs_cfg_if.sink   i_cfg
);
    import rbs_pkg::*;
    `include "assert_macros.svh"

    // Configuration registers.
    logic [TIME_W-1:0] r_min, r_max, r_plat;
    logic [GF_W-1:0]   r_gf;
    logic [PCT_W-1:0]  r_pct;

    // Architectural state.
    logic [TIME_W-1:0] r_fail_cnt, r_retry, r_prev;

    // Working registers.
    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [TIME_W-1:0] r_now, r_rnd, r_base, r_v, r_cnt, r_range, r_jit;
    logic              r_crossed, r_div_go;
    logic [PROD_W-1:0] r_prod;
    logic [PCT_W-1:0]  r_frac;

    // Output register.
    logic              r_ov, r_o_allowed;
    logic [TIME_W-1:0] r_o_delay, r_o_next, r_o_total;

    logic              in_acc, out_load;
    logic [TIME_W-1:0] base_sel, base_cap, base_fin;
    logic [TIME_W-1:0] mul_a;
    logic [GF_W-1:0]   mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [PCT_W-1:0]  pct_eff;
    logic [PROD_W-FRAC_W-1:0] g_raw;
    logic [TIME_W-1:0] g_cap, g_fin;
    logic              g_cross;
    logic [TIME_W-1:0] v_fix;
    logic [2*TIME_W-1:0] rcp_prod;
    logic [TIME_W-1:0] hundred_a, rem100;
    logic [2*PCT_W-1:0] frac_mul;
    logic [2*PCT_W+FRC_W-1:0] frac_scaled;
    logic [TIME_W-1:0] frac_q, range_fin;
    logic              div_done;
    logic [DVD_W-1:0]  div_dvd;
    logic [DEN_W-1:0]  div_rem, div_den;
    logic [TIME_W+1:0] d_raw, d_lo;
    logic [TIME_W-1:0] d_fin;
    logic [TIME_W-1:0] fin_retry, fin_prev, fin_cnt, diff;
    logic              fin_allowed;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_load    = (r_state == S_FIN) && (!r_ov || o_out.ready);

    // Base delay: floor override or minimum, capped at maximum, at least one.
    assign base_sel = (i_in.floor_ms != '0) ? i_in.floor_ms : r_min;
    assign base_cap = (base_sel > r_max) ? r_max : base_sel;
    assign base_fin = (base_cap == '0) ? TIME_W'(1) : base_cap;

    // Shared multiplier: growth factor during growth, jitter percent after.
    assign pct_eff = (r_pct > PCT_CAP) ? PCT_CAP : r_pct;
    assign mul_a   = (r_state == S_DQ) ? r_range : r_v;
    assign mul_b   = (r_state == S_DQ) ? GF_W'(pct_eff) : r_gf;
    assign mul_p   = {{GF_W{1'b0}}, mul_a} * {{TIME_W{1'b0}}, mul_b};

    // Growth step: truncate, saturate at maximum, cap once at the plateau.
    assign g_raw = r_prod[PROD_W-1:FRAC_W];
    always_comb begin
        g_cap   = (g_raw > {{(PROD_W-FRAC_W-TIME_W){1'b0}}, r_max}) ? r_max
                                                                   : g_raw[TIME_W-1:0];
        g_fin   = g_cap;
        g_cross = r_crossed;
        if (r_plat != '0 && !r_crossed && g_cap >= r_plat) begin
            g_fin   = r_plat;
            g_cross = 1'b1;
        end
    end

    // Final clamp of the grown value to the range from base to maximum.
    always_comb begin
        v_fix = (r_v > r_max) ? r_max : r_v;
        if (v_fix < r_base) begin
            v_fix = r_base;
        end
    end

    // Jitter span: value/100 by reciprocal, then quotient*pct plus the
    // remainder's share, (value mod 100)*pct/100, by a small reciprocal.
    assign rcp_prod    = {{TIME_W{1'b0}}, r_v} * {{TIME_W{1'b0}}, RCP_100};
    // 100*a built from shifts: 64 + 32 + 4.
    assign hundred_a   = (r_range << 6) + (r_range << 5) + (r_range << 2);
    assign rem100      = r_v - hundred_a;
    assign frac_mul    = {{PCT_W{1'b0}}, r_frac} * {{PCT_W{1'b0}}, pct_eff};
    assign frac_scaled = {{FRC_W{1'b0}}, frac_mul} * {{(2*PCT_W){1'b0}}, RCP_FRC};
    assign frac_q      = TIME_W'(frac_scaled >> FRC_SH);
    assign range_fin   = r_range + frac_q;

    // Divider operands: the random draw modulo the full jitter span.
    assign div_dvd = r_rnd;
    assign div_den = {r_range, 1'b1};

    rbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (div_dvd),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Jittered delay, clamped to the range from minimum to maximum.
    always_comb begin
        d_raw = {2'b00, r_v} + {2'b00, r_jit} - {2'b00, r_range};
        d_lo  = (d_raw < {2'b00, r_min}) ? {2'b00, r_min} : d_raw;
        d_fin = (d_lo > {2'b00, r_max}) ? r_max : d_lo[TIME_W-1:0];
    end

    // State after the transaction and the wrap-safe allowed test.
    always_comb begin
        fin_retry = r_retry;
        fin_prev  = r_prev;
        fin_cnt   = r_fail_cnt;
        case (r_op)
            OP_FAIL: begin
                fin_prev  = d_fin;
                fin_retry = r_now + d_fin;
                fin_cnt   = r_fail_cnt + 1'b1;
            end
            OP_CLEAR: begin
                fin_prev  = '0;
                fin_retry = '0;
                fin_cnt   = '0;
            end
            default: begin
            end
        endcase
        diff        = r_now - fin_retry;
        fin_allowed = (fin_retry == '0) || (diff < TIME_HALF);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.opcode == OP_FAIL) ? S_GMUL : S_FIN;
                end
            end
            S_GMUL: n_state = (r_cnt == r_fail_cnt) ? S_FIX : S_GCHK;
            S_GCHK: n_state = (g_fin == r_v) ? S_FIX : S_GMUL;
            S_FIX:  n_state = S_PMUL;
            S_PMUL: n_state = S_DQ;
            S_DQ:   n_state = S_DADJ;
            S_DADJ: n_state = (range_fin == '0) ? S_FIN : S_DM;
            S_DM: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers, configuration and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_div_go   <= 1'b0;
            r_ov       <= 1'b0;
            r_min      <= RST_MIN;
            r_max      <= RST_MAX;
            r_gf       <= RST_GROWTH;
            r_pct      <= RST_JITTER;
            r_plat     <= RST_PLATEAU;
            r_fail_cnt <= '0;
            r_retry    <= '0;
            r_prev     <= '0;
        end else begin
            r_state  <= n_state;
            r_div_go <= (r_state == S_DADJ) && (range_fin != '0);
            if (out_load) begin
                r_ov       <= 1'b1;
                r_fail_cnt <= fin_cnt;
                r_retry    <= fin_retry;
                r_prev     <= fin_prev;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_MIN:     r_min  <= i_cfg.data;
                    REG_MAX:     r_max  <= i_cfg.data;
                    REG_GROWTH:  r_gf   <= i_cfg.data[GF_W-1:0];
                    REG_JITTER:  r_pct  <= i_cfg.data[PCT_W-1:0];
                    REG_PLATEAU: r_plat <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_in.opcode;
                r_now   <= i_in.now_ms;
                r_rnd   <= i_in.random_value;
                r_base  <= base_fin;
                r_cnt   <= '0;
                r_range <= '0;
                r_jit   <= '0;
                if (r_plat != '0 && base_fin >= r_plat) begin
                    r_v       <= r_plat;
                    r_crossed <= 1'b1;
                end else begin
                    r_v       <= base_fin;
                    r_crossed <= 1'b0;
                end
            end
            S_GMUL: r_prod <= mul_p;
            S_GCHK: begin
                r_v       <= g_fin;
                r_crossed <= g_cross;
                r_cnt     <= r_cnt + 1'b1;
            end
            S_FIX:  r_v <= v_fix;
            S_PMUL: r_range <= TIME_W'(rcp_prod >> RCP_SH);
            S_DQ: begin
                r_range <= mul_p[TIME_W-1:0];
                r_frac  <= rem100[PCT_W-1:0];
            end
            S_DADJ: r_range <= range_fin;
            S_DM: begin
                if (div_done) begin
                    r_jit <= div_rem[TIME_W-1:0];
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_o_allowed <= fin_allowed;
            r_o_delay   <= fin_prev;
            r_o_next    <= fin_retry;
            r_o_total   <= fin_cnt;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.attempt_allowed = r_o_allowed;
    assign o_out.delay_ms        = r_o_delay;
    assign o_out.next_attempt_ms = r_o_next;
    assign o_out.attempt_total   = r_o_total;

    `RBS_ASSERT(a_grow_bound, i_clk, i_rst_n, (r_state == S_GCHK) |-> (r_cnt < r_fail_cnt), "growth step beyond failure count")
    `RBS_ASSERT(a_jit_span, i_clk, i_rst_n, (r_state == S_FIN) |-> ({1'b0, r_jit} <= {r_range, 1'b0}), "jitter outside span")
    `RBS_ASSERT(a_div_go, i_clk, i_rst_n, r_div_go |-> (r_state == S_DM), "divider started outside the divide state")

endmodule

[dv/retry_backoff_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// retry_backoff_checker
// Watches the input, result and register channels of the retry backoff
// scheduler, predicts every result from its own copy of the state and the
// registers, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module retry_backoff_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rbs_in_if    in_ch,
    rbs_out_if   out_ch,
    rbs_cfg_if   cfg_ch,
    output int   o_errors,
    output int   o_pending
);
    import rbs_pkg::*;

    typedef struct packed {
        logic              allowed;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] next_at;
        logic [TIME_W-1:0] total;
    } t_backoff_result;

    // Predicted register file.
    logic [TIME_W-1:0] min_ms, max_ms, plateau;
    logic [GF_W-1:0]   factor;
    logic [PCT_W-1:0]  jitter_pct;

    // Predicted scheduler state.
    logic [TIME_W-1:0] fail_count, retry_at, last_delay;

    t_backoff_result pending_results[$];
    int errors;

    assign o_errors  = errors;
    assign o_pending = pending_results.size();

    // Grows the base up to once per earlier failure, with plateau restart.
    function automatic logic [TIME_W-1:0] grown_delay(input logic [TIME_W-1:0] base);
        logic [63:0] v, g;
        bit crossed;
        logic [TIME_W-1:0] i;
        v = base;
        crossed = 0;
        if (plateau != 0 && v >= plateau) begin
            v = plateau;
            crossed = 1;
        end
        for (i = 0; i < fail_count; i++) begin
            g = (v * factor) >> FRAC_W;
            if (g > max_ms) g = max_ms;
            if (plateau != 0 && !crossed && g >= plateau) begin
                g = plateau;
                crossed = 1;
            end
            if (g == v) break;
            v = g;
        end
        if (v > max_ms) v = max_ms;
        if (v < base) v = base;
        return v[TIME_W-1:0];
    endfunction

    // Full delay of one failure: base, growth, jitter and final clamps.
    function automatic logic [TIME_W-1:0] backoff_delay(input logic [TIME_W-1:0] floor_ms,
                                                        input logic [TIME_W-1:0] rnd);
        logic [TIME_W-1:0] base, v, pct;
        logic [63:0] span_half;
        longint jit, d;
        base = (floor_ms != 0) ? floor_ms : min_ms;
        if (base > max_ms) base = max_ms;
        if (base == 0) base = 1;
        v = grown_delay(base);
        pct = (jitter_pct > PCT_CAP) ? PCT_CAP : jitter_pct;
        span_half = (64'(v) * pct) / 100;
        jit = 0;
        if (span_half != 0)
            jit = longint'(64'(rnd) % (2 * span_half + 1)) - longint'(span_half);
        d = longint'(64'(v)) + jit;
        if (d < longint'(64'(min_ms))) d = longint'(64'(min_ms));
        if (d > longint'(64'(max_ms))) d = longint'(64'(max_ms));
        return d[TIME_W-1:0];
    endfunction

    task automatic report(input string what, input logic [TIME_W-1:0] want,
                          input logic [TIME_W-1:0] got);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        errors++;
    endtask

    // Register writes, input transactions and result transactions.
    always @(posedge i_clk) begin
        t_backoff_result want, got;
        if (!i_rst_n) begin
            min_ms     <= RST_MIN;
            max_ms     <= RST_MAX;
            factor     <= RST_GROWTH;
            jitter_pct <= RST_JITTER;
            plateau    <= RST_PLATEAU;
            fail_count = 0;
            retry_at   = 0;
            last_delay = 0;
            pending_results.delete();
            errors     = (errors > 0) ? errors : 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_MIN:     min_ms     <= cfg_ch.data;
                    REG_MAX:     max_ms     <= cfg_ch.data;
                    REG_GROWTH:  factor     <= cfg_ch.data[GF_W-1:0];
                    REG_JITTER:  jitter_pct <= cfg_ch.data[PCT_W-1:0];
                    REG_PLATEAU: plateau    <= cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.opcode)
                    OP_FAIL: begin
                        last_delay = backoff_delay(in_ch.floor_ms, in_ch.random_value);
                        retry_at   = in_ch.now_ms + last_delay;
                        fail_count = fail_count + 1;
                    end
                    OP_CLEAR: begin
                        fail_count = 0;
                        retry_at   = 0;
                        last_delay = 0;
                    end
                    default: ;
                endcase
                want.allowed = (retry_at == 0) || ((in_ch.now_ms - retry_at) < TIME_HALF);
                want.delay   = last_delay;
                want.next_at = retry_at;
                want.total   = fail_count;
                pending_results.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.attempt_allowed, out_ch.delay_ms, out_ch.next_attempt_ms,
                        out_ch.attempt_total};
                if (pending_results.size() == 0) begin
                    $display("%0t: result transaction with no prediction waiting", $realtime);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.allowed !== want.allowed)
                        report("attempt_allowed", want.allowed, got.allowed);
                    if (got.delay !== want.delay)
                        report("delay_ms", want.delay, got.delay);
                    if (got.next_at !== want.next_at)
                        report("next_attempt_ms", want.next_at, got.next_at);
                    if (got.total !== want.total)
                        report("attempt_total", want.total, got.total);
                end
            end
        end
    end

    initial errors = 0;

endmodule

[dv/retry_backoff_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// retry_backoff_scheduler_tb
// Drives failure, poll, clear and unused-opcode transactions under a range
// of register settings with random gaps and result stalls; the checker
// predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module retry_backoff_scheduler_tb;
    import rbs_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int MAX_GAP = 18;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending;
    bit   steady;        // no idling on either side while set
    int   fails_since_clear, clear_after;
    logic [TIME_W-1:0] clock_ms;

    rbs_in_if  in_ch();
    rbs_out_if out_ch();
    rbs_cfg_if cfg_ch();

    retry_backoff_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    retry_backoff_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_ch    (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Half full-range words, with the extremes and small values making up the rest.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 2000);
            default: return $urandom;
        endcase
    endfunction

    // Result side: stall a random number of cycles before each transaction.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send(input logic [OP_W-1:0] op, input logic [31:0] now,
                        input logic [31:0] floor_ms, input logic [31:0] rnd);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.now_ms       <= now;
        in_ch.floor_ms     <= floor_ms;
        in_ch.random_value <= rnd;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == OP_FAIL) fails_since_clear++;
        if (op == OP_CLEAR) fails_since_clear = 0;
    endtask

    // Lets every prediction drain before the registers change.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [31:0] min_ms, input logic [31:0] max_ms,
                             input logic [31:0] factor, input logic [31:0] pct,
                             input logic [31:0] plateau);
        settle();
        write_reg(REG_MIN, min_ms);
        write_reg(REG_MAX, max_ms);
        write_reg(REG_GROWTH, factor);
        write_reg(REG_JITTER, pct);
        write_reg(REG_PLATEAU, plateau);
    endtask

    // One random transaction: mostly failures in bounded runs between clears.
    task automatic random_item();
        logic [OP_W-1:0] op;
        int pick;
        pick = $urandom_range(0, 99);
        if (fails_since_clear >= clear_after) begin
            op = OP_CLEAR;
            clear_after = $urandom_range(1, 14);
        end else if (pick < 62) op = OP_FAIL;
        else if (pick < 82) op = OP_POLL;
        else if (pick < 90) op = OP_CLEAR;
        else op = OP_SPARE;
        if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 400000);
        send(op, clock_ms, ($urandom_range(0, 2) == 0) ? 32'd0 : pick_word(), pick_word());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        steady          = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_POLL;
        in_ch.now_ms    = '0;
        in_ch.floor_ms  = '0;
        in_ch.random_value = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_MIN;
        cfg_ch.data     = '0;
        fails_since_clear = 0;
        clear_after     = 8;
        clock_ms        = 32'd5000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings.
        send(OP_POLL, 32'd0, 32'd0, 32'd0);
        send(OP_FAIL, 32'd100, 32'd0, 32'd0);
        send(OP_POLL, 32'd100, 32'd0, 32'd0);
        send(OP_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_FAIL, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
        send(OP_SPARE, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_FAIL, 32'd20, 32'd70000, 32'd12345);
        send(OP_CLEAR, 32'd0, 32'd0, 32'd0);
        // Next attempt lands exactly on the wrap to zero: jitter draw is centred.
        send(OP_FAIL, 32'hFFFF_FFFF - 32'd999, 32'd1000, 32'd100);
        send(OP_POLL, 32'd3, 32'd0, 32'd0);
        send(OP_CLEAR, 32'd5, 32'd0, 32'd0);

        // Max below one, and min above max.
        load_regs(32'd500, 32'd0, 32'd512, 32'd10, 32'd0);
        send(OP_FAIL, 32'd10, 32'd0, 32'd7);
        send(OP_FAIL, 32'd10, 32'd9, 32'd7);
        load_regs(32'd900000, 32'd4000, 32'd8191, 32'd127, 32'hFFFF_FFFF);
        send(OP_FAIL, 32'd10, 32'd0, 32'hFFFF_FFFF);
        send(OP_FAIL, 32'd10, 32'd3, 32'd0);
        // Factor at or below one, and an index beyond the register list.
        load_regs(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
        write_reg(3'd5, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'd0);
        send(OP_FAIL, 32'd1, 32'hFFFF_FFFF, 32'd1);
        send(OP_FAIL, 32'd1, 32'd0, 32'd1);
        send(OP_CLEAR, 32'd1, 32'd0, 32'd1);
        load_regs(32'd1, 32'hFFFF_FFFF, 32'd256, 32'd50, 32'd1);
        send(OP_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_FAIL, 32'd0, 32'd300, 32'd77);
        send(OP_CLEAR, 32'd0, 32'd0, 32'd0);

        // Random phases, each under its own settings.
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                0: load_regs(RST_MIN, RST_MAX, RST_GROWTH, RST_JITTER, RST_PLATEAU);
                1: load_regs(32'd0, 32'hFFFF_FFFF, 32'd4096, 32'd100, 32'd0);
                2: load_regs(32'd1, 32'hFFFF_FFFF, 32'd257, 32'd50, 32'hFFFF_FFFF);
                3: load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd8191, 32'd127, 32'd1);
                4: load_regs(32'd200, 32'd100000, 32'd384, 32'd25, 32'd20000);
                5: load_regs(32'd5000, 32'd10, 32'd700, 32'd0, 32'd50);
                6: load_regs(32'd0, 32'd0, 32'd255, 32'd51, 32'd0);
                7: load_regs($urandom, $urandom, $urandom_range(0, 8191),
                             $urandom_range(0, 127), $urandom);
                default: load_regs($urandom_range(0, 3000), $urandom_range(1000, 2000000),
                                   $urandom_range(257, 4096), $urandom_range(0, 100),
                                   $urandom_range(0, 500000));
            endcase
            steady = (phase == 2) || (phase == 6);
            for (int n = 0; n < 110; n++) begin
                random_item();
                // Hold off until the block has drained, once per phase.
                if (n == 55) settle();
            end
        end

        steady = 1'b0;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
